### rtl/alq_pkg.sv
// ----------------------------------------------------------------------------
// alq_pkg
// Types and constants for the averaged level quantizer.
// ----------------------------------------------------------------------------
package alq_pkg;

	localparam int WINDOW     = 8;
	localparam int IDX_W      = $clog2(WINDOW);
	localparam int SAMPLE_W   = 11;
	localparam int SUM_W      = SAMPLE_W + IDX_W;
	localparam int AVG_W      = SAMPLE_W - 1;
	localparam int LEVEL_W    = 12;

	// full scale 600 mV reference times 6 for the 1/6 gain, over 2^10 codes
	localparam int MV_SCALE   = 600 * 6;
	localparam int SCALE_W    = 12;
	localparam int ADC_RES    = 10;
	localparam int PROD_W     = AVG_W + SCALE_W;

	localparam int DIV_STEPS  = LEVEL_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [LEVEL_W-1:0] STEP_SIZE_RESET = LEVEL_W'(100);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_DIV,
		ST_EMIT
	} alq_state_t;

endpackage

### rtl/averaged_level_quantizer.sv
// timing: a sample request is taken in idle, then passes the scale state, the
// bit-per-cycle restoring divider and the compare state; a new sample is taken
// only once the last one is through. a result waiting at the output delays the
// next sample when the new step differs from the last step.
// reset: ring, running sum, ring index and last step clear to zero, step size
// returns to 100 mV; reset is asynchronous, active low.
// ----------------------------------------------------------------------------
// averaged_level_quantizer
// Moving average over a sample ring, scaled to millivolts and divided by the
// configured step size; a step is reported only when it changes.
// ----------------------------------------------------------------------------
module averaged_level_quantizer
	import alq_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic        [LEVEL_W-1:0]  step,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic        [LEVEL_W-1:0]  step_size_mv
);

	alq_state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] ring_q [WINDOW];
	logic        [IDX_W-1:0]    idx_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic        [LEVEL_W-1:0]  step_size_q;
	logic        [LEVEL_W-1:0]  div_q;
	logic        [LEVEL_W-1:0]  quot_q;
	logic        [LEVEL_W-1:0]  rem_q;
	logic        [CNT_W-1:0]    cnt_q;
	logic        [LEVEL_W-1:0]  last_step_q;
	logic        [LEVEL_W-1:0]  step_q;
	logic                       out_valid_q;

	logic                       in_acc;
	logic signed [SUM_W-1:0]    sum_next;
	logic        [AVG_W-1:0]    avg;
	logic        [PROD_W-1:0]   prod;
	logic        [LEVEL_W-1:0]  mv;
	logic        [LEVEL_W:0]    trial;
	logic                       trial_ge;
	logic                       out_free;
	logic                       load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign step      = step_q;
	assign out_free  = !out_valid_q || out_ready;

	// running sum: drop the overwritten entry, add the new one
	assign sum_next = sum_q - SUM_W'(ring_q[idx_q]) + SUM_W'(sample);

	// average truncates toward zero; non-positive sums give 0 mV anyway
	always_comb begin
		if (sum_q > 0) begin
			avg = AVG_W'(sum_q / WINDOW);
		end else begin
			avg = '0;
		end
		prod = PROD_W'(avg) * PROD_W'(MV_SCALE);
		mv   = LEVEL_W'(prod >> ADC_RES);
	end

	// one restoring divide step
	assign trial    = {rem_q, quot_q[LEVEL_W-1]};
	assign trial_ge = (trial >= {1'b0, div_q});

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (quot_q == last_step_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring_q[i] <= '0;
			end
			idx_q <= '0;
			sum_q <= '0;
		end else if (in_acc) begin
			ring_q[idx_q] <= sample;
			sum_q         <= sum_next;
			if (idx_q == IDX_W'(WINDOW - 1)) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= STEP_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_size_q <= step_size_mv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_SCALE) begin
			cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// divider datapath: quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE) begin
			quot_q <= mv;
			rem_q  <= '0;
			div_q  <= (step_size_q == '0) ? LEVEL_W'(1) : step_size_q;
		end else if (state_q == ST_DIV) begin
			quot_q <= {quot_q[LEVEL_W-2:0], trial_ge};
			if (trial_ge) begin
				rem_q <= LEVEL_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[LEVEL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_step_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				last_step_q <= quot_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			step_q <= quot_q;
		end
	end

`ifndef SYNTHESIS
	a_div_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(DIV_STEPS))
		else $error("divide counter out of range");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < div_q)
		else $error("divider remainder not below divisor");

	a_new_step_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && step_q == last_step_q)
		else $error("reported step not recorded as last step");

	a_no_input_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("sample request taken while a sample is in progress");
`endif

endmodule
